// ===== hdl/gbnsc_pkg.sv =====
// ----------------------------------------------------------------------------
// gbnsc_pkg
// Types, codes and helpers shared by the Go-Back-N sender control block.
// ----------------------------------------------------------------------------
package gbnsc_pkg;

  // Largest window the hardware supports and the most results one event yields.
  localparam int unsigned WindowMax = 16;
  localparam int unsigned ResultCap = 16;
  localparam int unsigned WinCap    = (WindowMax < ResultCap) ? WindowMax : ResultCap;
  localparam int unsigned QueueDepth = 2;

  // Reset values of the configuration registers.
  localparam logic [31:0] PacketCountRst   = 32'd1;
  localparam logic [4:0]  WindowSizeRst    = 5'd16;
  localparam logic [15:0] RetryLimitRst    = 16'd500;
  localparam logic [7:0]  HeaderAckTypeRst = 8'd0;

  // Reply type codes with a fixed meaning.
  localparam logic [7:0] TypeDataAck = 8'd2;
  localparam logic [7:0] TypeFinAck  = 8'd4;

  typedef enum logic [1:0] {
    OpStart   = 2'd0,
    OpReply   = 2'd1,
    OpTimeout = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KindHeader = 2'd0,
    KindData   = 2'd1,
    KindFin    = 2'd2,
    KindNone   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    StatusIdle    = 3'd0,
    StatusRunning = 3'd1,
    StatusDone    = 3'd2,
    StatusHdrFail = 3'd3,
    StatusFinFail = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    PhIdle    = 3'd0,
    PhHeader  = 3'd1,
    PhData    = 3'd2,
    PhFin     = 3'd3,
    PhDone    = 3'd4,
    PhHdrFail = 3'd5,
    PhFinFail = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    CfgPacketCount   = 2'd0,
    CfgWindowSize    = 2'd1,
    CfgRetryLimit    = 2'd2,
    CfgHeaderAckType = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FrIdle    = 3'd0,
    FrUpdate  = 3'd1,
    FrRaise   = 3'd2,
    FrAdvance = 3'd3,
    FrPush    = 3'd4
  } front_state_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  reply_type;
    logic [31:0] reply_number;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  send_kind;
    logic [31:0] send_sequence;
    logic        last;
    logic [2:0]  status;
  } out_item_t;

  // One queued command: a run of cnt items starting at seq.
  typedef struct packed {
    kind_e       kind;
    logic [31:0] seq;
    logic [4:0]  cnt;
    status_e     status;
  } cmd_t;

  function automatic status_e status_of(phase_e ph);
    status_e st;
    unique case (ph)
      PhHeader, PhData, PhFin: st = StatusRunning;
      PhDone:                  st = StatusDone;
      PhHdrFail:               st = StatusHdrFail;
      PhFinFail:               st = StatusFinFail;
      default:                 st = StatusIdle;
    endcase
    return st;
  endfunction

endpackage

// ===== hdl/gbnsc_queue.sv =====
// ----------------------------------------------------------------------------
// gbnsc_queue
// Short command queue between the event front end and the send sequencer.
// ----------------------------------------------------------------------------
module gbnsc_queue #(
  parameter int unsigned DEPTH = gbnsc_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  gbnsc_pkg::cmd_t   push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output gbnsc_pkg::cmd_t   pop_data_o,
  output logic              empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  gbnsc_pkg::cmd_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic            do_push, do_pop;

  assign full_o     = (fill_q == FullCnt);
  assign empty_o    = (fill_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/gbnsc_front.sv =====
// ----------------------------------------------------------------------------
// gbnsc_front
// Accepts events, holds the transfer state and configuration, and turns each
// event into one send command for the queue.
// ----------------------------------------------------------------------------
module gbnsc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  gbnsc_pkg::in_item_t  in_item_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  output logic                 push_o,
  output gbnsc_pkg::cmd_t      push_data_o,
  input  logic                 full_i
);

  gbnsc_pkg::front_state_e state_q, state_d;
  gbnsc_pkg::in_item_t     ev_q;
  gbnsc_pkg::phase_e       phase_q, phase_d;
  logic [31:0]             base_q, base_d;
  logic [31:0]             next_q, next_d;
  logic [15:0]             retry_q, retry_d;
  gbnsc_pkg::cmd_t         cmd_q, cmd_d;

  logic [31:0] packet_count_q;
  logic [4:0]  window_size_q;
  logic [15:0] retry_limit_q;
  logic [7:0]  header_ack_type_q;

  logic [31:0] count_eff;
  logic [4:0]  win_eff;
  logic        running;
  logic [16:0] retry_inc;
  logic        retry_out;
  logic signed [33:0] room_win, room_cnt, room;
  logic [4:0]  run_len;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != gbnsc_pkg::FrIdle);
  assign push_o      = (state_q == gbnsc_pkg::FrPush);
  assign push_data_o = cmd_q;

  assign count_eff = (packet_count_q == '0) ? 32'd1 : packet_count_q;
  always_comb begin
    win_eff = (window_size_q == '0) ? 5'd1 : window_size_q;
    if (win_eff > 5'(gbnsc_pkg::WinCap)) begin
      win_eff = 5'(gbnsc_pkg::WinCap);
    end
  end

  assign running = (phase_q == gbnsc_pkg::PhHeader) || (phase_q == gbnsc_pkg::PhData) ||
                   (phase_q == gbnsc_pkg::PhFin);
  assign retry_inc = {1'b0, retry_q} + 17'd1;
  assign retry_out = (retry_inc >= {1'b0, retry_limit_q});

  // Room left in the window and in the transfer, measured from next_q.
  assign room_win = $signed({2'b00, base_q}) + $signed({29'd0, win_eff}) -
                    $signed({2'b00, next_q});
  assign room_cnt = $signed({2'b00, count_eff}) - $signed({2'b00, next_q});
  assign room     = (room_win < room_cnt) ? room_win : room_cnt;
  assign run_len  = (room > 34'sd0) ? room[4:0] : 5'd0;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    base_d  = base_q;
    next_d  = next_q;
    retry_d = retry_q;
    cmd_d   = cmd_q;
    unique case (state_q)
      gbnsc_pkg::FrIdle: begin
        if (in_valid_i) begin
          state_d = gbnsc_pkg::FrUpdate;
        end
      end
      gbnsc_pkg::FrUpdate: begin
        cmd_d.kind = gbnsc_pkg::KindNone;
        cmd_d.seq  = '0;
        cmd_d.cnt  = 5'd1;
        state_d    = gbnsc_pkg::FrPush;
        if (ev_q.op == gbnsc_pkg::OpStart) begin
          if (!running) begin
            base_d  = '0;
            next_d  = '0;
            retry_d = '0;
            if (retry_limit_q == '0) begin
              phase_d = gbnsc_pkg::PhHdrFail;
            end else begin
              phase_d    = gbnsc_pkg::PhHeader;
              cmd_d.kind = gbnsc_pkg::KindHeader;
            end
          end
        end else if ((ev_q.op == gbnsc_pkg::OpReply || ev_q.op == gbnsc_pkg::OpTimeout) &&
                     running) begin
          priority if (phase_q == gbnsc_pkg::PhHeader) begin
            if (ev_q.op == gbnsc_pkg::OpReply && ev_q.reply_type == header_ack_type_q) begin
              phase_d = gbnsc_pkg::PhData;
              base_d  = '0;
              next_d  = '0;
              state_d = gbnsc_pkg::FrRaise;
            end else begin
              retry_d = retry_inc[15:0];
              if (retry_out) begin
                phase_d = gbnsc_pkg::PhHdrFail;
              end else begin
                cmd_d.kind = gbnsc_pkg::KindHeader;
              end
            end
          end else if (phase_q == gbnsc_pkg::PhData) begin
            if (ev_q.op == gbnsc_pkg::OpReply) begin
              if (ev_q.reply_type == gbnsc_pkg::TypeDataAck && ev_q.reply_number >= base_q) begin
                // Cumulative ack; the base saturates at the packet count.
                base_d = (ev_q.reply_number >= count_eff - 32'd1) ? count_eff :
                         ev_q.reply_number + 32'd1;
              end
            end else begin
              next_d = base_q;
            end
            state_d = gbnsc_pkg::FrRaise;
          end else begin
            if (ev_q.op == gbnsc_pkg::OpReply && ev_q.reply_type == gbnsc_pkg::TypeFinAck) begin
              phase_d = gbnsc_pkg::PhDone;
            end else begin
              retry_d = retry_inc[15:0];
              if (retry_out) begin
                phase_d = gbnsc_pkg::PhFinFail;
              end else begin
                cmd_d.kind = gbnsc_pkg::KindFin;
                cmd_d.seq  = count_eff;
              end
            end
          end
        end
        cmd_d.status = gbnsc_pkg::status_of(phase_d);
      end
      gbnsc_pkg::FrRaise: begin
        if (base_q >= count_eff) begin
          // All data acknowledged: move on to the FIN handshake, or fail it at once when the retry limit is zero.
          retry_d   = '0;
          cmd_d.cnt = 5'd1;
          if (retry_limit_q == '0) begin
            phase_d    = gbnsc_pkg::PhFinFail;
            cmd_d.kind = gbnsc_pkg::KindNone;
            cmd_d.seq  = '0;
          end else begin
            phase_d    = gbnsc_pkg::PhFin;
            cmd_d.kind = gbnsc_pkg::KindFin;
            cmd_d.seq  = count_eff;
          end
          cmd_d.status = gbnsc_pkg::status_of(phase_d);
          state_d      = gbnsc_pkg::FrPush;
        end else begin
          if (next_q < base_q) begin
            next_d = base_q;
          end
          state_d = gbnsc_pkg::FrAdvance;
        end
      end
      gbnsc_pkg::FrAdvance: begin
        cmd_d.status = gbnsc_pkg::StatusRunning;
        if (run_len == '0) begin
          cmd_d.kind = gbnsc_pkg::KindNone;
          cmd_d.seq  = '0;
          cmd_d.cnt  = 5'd1;
        end else begin
          cmd_d.kind = gbnsc_pkg::KindData;
          cmd_d.seq  = next_q;
          cmd_d.cnt  = run_len;
        end
        next_d  = next_q + {27'd0, run_len};
        state_d = gbnsc_pkg::FrPush;
      end
      gbnsc_pkg::FrPush: begin
        if (!full_i) begin
          state_d = gbnsc_pkg::FrIdle;
        end
      end
      default: begin
        state_d = gbnsc_pkg::FrIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gbnsc_pkg::FrIdle;
      phase_q <= gbnsc_pkg::PhIdle;
      base_q  <= '0;
      next_q  <= '0;
      retry_q <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      base_q  <= base_d;
      next_q  <= next_d;
      retry_q <= retry_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      packet_count_q    <= gbnsc_pkg::PacketCountRst;
      window_size_q     <= gbnsc_pkg::WindowSizeRst;
      retry_limit_q     <= gbnsc_pkg::RetryLimitRst;
      header_ack_type_q <= gbnsc_pkg::HeaderAckTypeRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (gbnsc_pkg::cfg_idx_e'(cfg_index_i))
        gbnsc_pkg::CfgPacketCount:   packet_count_q    <= cfg_data_i;
        gbnsc_pkg::CfgWindowSize:    window_size_q     <= cfg_data_i[4:0];
        gbnsc_pkg::CfgRetryLimit:    retry_limit_q     <= cfg_data_i[15:0];
        gbnsc_pkg::CfgHeaderAckType: header_ack_type_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      ev_q <= in_item_i;
    end
    cmd_q <= cmd_d;
  end

endmodule

// ===== hdl/gbnsc_back.sv =====
// ----------------------------------------------------------------------------
// gbnsc_back
// Send sequencer: expands each queued command into its result beats, one per
// cycle while the output is not stalled, behind an output register.
// ----------------------------------------------------------------------------
module gbnsc_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gbnsc_pkg::cmd_t       cmd_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output gbnsc_pkg::out_item_t  out_item_o
);

  logic                 cur_valid_q, cur_valid_d;
  gbnsc_pkg::cmd_t      cur_q, cur_d;
  logic                 out_valid_q, out_valid_d;
  gbnsc_pkg::out_item_t out_q, out_d;
  logic                 load, emit, finish;

  assign load   = !out_valid_q || !out_stall_i;
  assign emit   = load && cur_valid_q;
  assign finish = emit && (cur_q.cnt == 5'd1);
  assign pop_o  = !empty_i && (!cur_valid_q || finish);

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    cur_valid_d = cur_valid_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (load) begin
      out_valid_d = cur_valid_q;
    end
    if (emit) begin
      out_d.send_kind     = cur_q.kind;
      out_d.send_sequence = cur_q.seq;
      out_d.last          = (cur_q.cnt == 5'd1);
      out_d.status        = cur_q.status;
    end
    if (pop_o) begin
      cur_valid_d = 1'b1;
      cur_d       = cmd_i;
    end else if (finish) begin
      cur_valid_d = 1'b0;
    end else if (emit) begin
      cur_d.seq = cur_q.seq + 32'd1;
      cur_d.cnt = cur_q.cnt - 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

endmodule

// ===== hdl/go_back_n_sender_control_top.sv =====
// ----------------------------------------------------------------------------
// go_back_n_sender_control_top
// Transmit-side control of a Go-Back-N sender with header and FIN handshakes.
//
//   Channel  Handshake               Payload
//   in       in_valid_i/in_stall_o   in_item_i (op, reply_type, reply_number)
//   out      out_valid_o/out_stall_i out_item_o (send_kind, sequence, last, status)
//   cfg      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// The front end takes one event at a time and steps through accept, update,
// window check and fill for a data event, and queue push; its input stalls
// until the push is taken. Result beats leave one per cycle while the output
// is not stalled. The command queue lets the front end take the next event
// while earlier beats are still draining.
// Reset is asynchronous and active low; no clearing pass is needed.
// A stalled output holds its beat; once the queue is full the input stalls.
// ----------------------------------------------------------------------------
module go_back_n_sender_control_top #(
  parameter int unsigned QUEUE_DEPTH = gbnsc_pkg::QueueDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  gbnsc_pkg::in_item_t   in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output gbnsc_pkg::out_item_t  out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [31:0]           cfg_data_i
);

  logic            push, full, pop, empty;
  gbnsc_pkg::cmd_t push_data, pop_data;

  gbnsc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  gbnsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  gbnsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (pop_data),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== hdl/gbnsc_checker.sv =====
// ----------------------------------------------------------------------------
// gbnsc_checker
// Port-level checks on the result channel of the sender control block.
// ----------------------------------------------------------------------------
module gbnsc_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input gbnsc_pkg::out_item_t out_item_o
);

  // A stalled beat stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result beat changed");

  // A beat that sends nothing is always the last beat of its event.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.send_kind == gbnsc_pkg::KindNone |-> out_item_o.last)
    else $error("nothing-to-send beat is not the last beat");

  // Only a data run spans several beats.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last |-> out_item_o.send_kind == gbnsc_pkg::KindData)
    else $error("multi-beat result is not a data run");

  // Beats of one data run carry consecutive sequence numbers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_item_o.last ##1 out_valid_o |->
      out_item_o.send_sequence == $past(out_item_o.send_sequence) + 32'd1)
    else $error("data run sequence is not consecutive");

endmodule

bind go_back_n_sender_control_top gbnsc_checker u_gbnsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Go-Back-N sender control block. A built-in
// predictor follows the header, data window and FIN phases, and every send
// beat is checked field by field. The bench runs directed cases for the
// register extremes and the handshake corner cases, a held-off receiver, and
// random transfers under several idle and stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam logic [1:0]  OpUnused   = 2'd3;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned TailCycles = 24;
  localparam int unsigned RandEvents = 95;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  gbnsc_pkg::in_item_t  in_item_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  gbnsc_pkg::out_item_t out_item_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [1:0]           cfg_index_i = '0;
  logic [31:0]          cfg_data_i = '0;

  go_back_n_sender_control_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Predictor copy of the registers and of the sender state.
  logic [31:0]       pkt_count = gbnsc_pkg::PacketCountRst;
  logic [4:0]        win_size = gbnsc_pkg::WindowSizeRst;
  logic [15:0]       retry_lim = gbnsc_pkg::RetryLimitRst;
  logic [7:0]        hdr_ack_type = gbnsc_pkg::HeaderAckTypeRst;
  gbnsc_pkg::phase_e ph = gbnsc_pkg::PhIdle;
  logic [31:0]       base = '0;
  logic [31:0]       nxt = '0;
  int unsigned       retries = 0;

  gbnsc_pkg::out_item_t burst[$];
  gbnsc_pkg::out_item_t cmds_due[$];
  gbnsc_pkg::out_item_t head_cmd;

  int idle_pct = 0;
  int stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned errors = 0;
  int unsigned events_sent = 0;
  int unsigned events_acted = 0;
  int unsigned beats_checked = 0;
  int unsigned input_stalls = 0;
  int unsigned done_cnt = 0;
  int unsigned hdr_fail_cnt = 0;
  int unsigned fin_fail_cnt = 0;
  int unsigned cycle_cnt = 0;

  function automatic logic [31:0] eff_count();
    return (pkt_count == '0) ? 32'd1 : pkt_count;
  endfunction

  function automatic void queue_send(gbnsc_pkg::kind_e kind, logic [31:0] seq);
    gbnsc_pkg::out_item_t c;
    c = '0;
    c.send_kind = kind;
    c.send_sequence = seq;
    burst.push_back(c);
  endfunction

  function automatic void try_header();
    if (retries >= retry_lim) ph = gbnsc_pkg::PhHdrFail;
    else queue_send(gbnsc_pkg::KindHeader, 32'd0);
  endfunction

  function automatic void try_fin();
    if (retries >= retry_lim) ph = gbnsc_pkg::PhFinFail;
    else queue_send(gbnsc_pkg::KindFin, eff_count());
  endfunction

  // Either all data is acknowledged and FIN starts, or the window is refilled.
  function automatic void fill_window();
    logic [31:0] win;
    logic [63:0] lim;
    if (base >= eff_count()) begin
      ph = gbnsc_pkg::PhFin;
      retries = 0;
      try_fin();
      return;
    end
    if (nxt < base) nxt = base;
    win = (win_size == '0) ? 32'd1 : 32'(win_size);
    if (win > gbnsc_pkg::WinCap) win = gbnsc_pkg::WinCap;
    lim = {32'd0, base} + {32'd0, win};
    while ({32'd0, nxt} < lim && nxt < eff_count()) begin
      queue_send(gbnsc_pkg::KindData, nxt);
      nxt++;
    end
  endfunction

  // Applies one accepted event to the sender state and queues its send beats.
  function automatic bit sender_react(gbnsc_pkg::in_item_t it);
    logic               running;
    bit                 acted;
    gbnsc_pkg::status_e st;
    gbnsc_pkg::phase_e  old_ph;
    running = (ph == gbnsc_pkg::PhHeader) || (ph == gbnsc_pkg::PhData) ||
              (ph == gbnsc_pkg::PhFin);
    acted = 1'b0;
    old_ph = ph;
    burst = {};
    if (it.op == gbnsc_pkg::OpStart) begin
      if (!running) begin
        acted = 1'b1;
        ph = gbnsc_pkg::PhHeader;
        base = '0;
        nxt = '0;
        retries = 0;
        try_header();
      end
    end else if ((it.op == gbnsc_pkg::OpReply || it.op == gbnsc_pkg::OpTimeout) &&
                 running) begin
      acted = 1'b1;
      if (ph == gbnsc_pkg::PhHeader) begin
        if (it.op == gbnsc_pkg::OpReply && it.reply_type == hdr_ack_type) begin
          ph = gbnsc_pkg::PhData;
          base = '0;
          nxt = '0;
          fill_window();
        end else begin
          retries++;
          try_header();
        end
      end else if (ph == gbnsc_pkg::PhData) begin
        if (it.op == gbnsc_pkg::OpReply) begin
          if (it.reply_type == gbnsc_pkg::TypeDataAck && it.reply_number >= base) begin
            base = (it.reply_number >= eff_count() - 1) ? eff_count()
                                                         : it.reply_number + 1;
          end
        end else begin
          nxt = base;
        end
        fill_window();
      end else begin
        if (it.op == gbnsc_pkg::OpReply && it.reply_type == gbnsc_pkg::TypeFinAck) begin
          ph = gbnsc_pkg::PhDone;
        end else begin
          retries++;
          try_fin();
        end
      end
    end
    if (burst.size() == 0) queue_send(gbnsc_pkg::KindNone, 32'd0);
    case (ph)
      gbnsc_pkg::PhHeader, gbnsc_pkg::PhData, gbnsc_pkg::PhFin:
        st = gbnsc_pkg::StatusRunning;
      gbnsc_pkg::PhDone:    st = gbnsc_pkg::StatusDone;
      gbnsc_pkg::PhHdrFail: st = gbnsc_pkg::StatusHdrFail;
      gbnsc_pkg::PhFinFail: st = gbnsc_pkg::StatusFinFail;
      default:              st = gbnsc_pkg::StatusIdle;
    endcase
    if (ph != old_ph) begin
      if (ph == gbnsc_pkg::PhDone) done_cnt++;
      if (ph == gbnsc_pkg::PhHdrFail) hdr_fail_cnt++;
      if (ph == gbnsc_pkg::PhFinFail) fin_fail_cnt++;
    end
    foreach (burst[k]) begin
      burst[k].status = st;
      burst[k].last = (k == burst.size() - 1);
      cmds_due.push_back(burst[k]);
    end
    return acted;
  endfunction

  // Random event shaped by the current phase: mostly the replies that move
  // the transfer forward, with timeouts, stray types and ignored events mixed in.
  function automatic gbnsc_pkg::in_item_t pick_event();
    gbnsc_pkg::in_item_t it;
    int unsigned         roll;
    logic [31:0]         span;
    it.op = gbnsc_pkg::OpReply;
    it.reply_type = 8'($urandom_range(255));
    it.reply_number = $urandom;
    roll = $urandom_range(99);
    if (roll < 4) begin
      it.op = OpUnused;
      return it;
    end
    case (ph)
      gbnsc_pkg::PhHeader: begin
        if (roll < 70) it.reply_type = hdr_ack_type;
        else if (roll < 85) it.op = gbnsc_pkg::OpTimeout;
      end
      gbnsc_pkg::PhData: begin
        if (roll < 65) begin
          it.reply_type = gbnsc_pkg::TypeDataAck;
          span = (nxt >= base) ? nxt - base : '0;
          if (base != '0 && roll < 12) it.reply_number = base - 1;
          else it.reply_number = base + $urandom_range(span);
        end else if (roll < 72) begin
          it.reply_type = gbnsc_pkg::TypeDataAck;
        end else if (roll < 85) begin
          it.op = gbnsc_pkg::OpTimeout;
        end else if (roll < 90) begin
          it.op = gbnsc_pkg::OpStart;
        end
      end
      gbnsc_pkg::PhFin: begin
        if (roll < 60) it.reply_type = gbnsc_pkg::TypeFinAck;
        else if (roll < 80) it.op = gbnsc_pkg::OpTimeout;
      end
      default: begin
        if (roll < 85) it.op = gbnsc_pkg::OpStart;
        else if (roll < 92) it.op = gbnsc_pkg::OpTimeout;
      end
    endcase
    return it;
  endfunction

  // Drives one event beat and holds it until the block takes it.
  task automatic offer_event(input gbnsc_pkg::in_item_t it, output bit acted);
    @(negedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) begin
      input_stalls++;
      @(posedge clk_i);
    end
    events_sent++;
    acted = sender_react(it);
    if (acted) events_acted++;
  endtask

  task automatic offer(logic [1:0] op, logic [7:0] rtype, logic [31:0] rnum);
    gbnsc_pkg::in_item_t it;
    bit                  acted;
    it.op = op;
    it.reply_type = rtype;
    it.reply_number = rnum;
    offer_event(it, acted);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (cmds_due.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(gbnsc_pkg::cfg_idx_e idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      gbnsc_pkg::CfgPacketCount:   pkt_count = value;
      gbnsc_pkg::CfgWindowSize:    win_size = value[4:0];
      gbnsc_pkg::CfgRetryLimit:    retry_lim = value[15:0];
      gbnsc_pkg::CfgHeaderAckType: hdr_ack_type = value[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(logic [31:0] count, logic [4:0] win, logic [15:0] lim,
                           logic [7:0] ack_type);
    write_reg(gbnsc_pkg::CfgPacketCount, count);
    write_reg(gbnsc_pkg::CfgWindowSize, 32'(win));
    write_reg(gbnsc_pkg::CfgRetryLimit, 32'(lim));
    write_reg(gbnsc_pkg::CfgHeaderAckType, 32'(ack_type));
  endtask

  task automatic test_handshake_failures();
    // With no attempts allowed the header handshake fails on start.
    configure(32'd5, 5'd4, 16'd0, 8'd0);
    offer(gbnsc_pkg::OpStart, 8'd0, 32'd0);
    wait_drained();
    configure(32'd5, 5'd4, 16'd2, 8'hFF);
    offer(OpUnused, 8'hFF, 32'hFFFF_FFFF);
    offer(gbnsc_pkg::OpTimeout, 8'd0, 32'd0);
    offer(gbnsc_pkg::OpStart, 8'd0, 32'd0);
    offer(gbnsc_pkg::OpReply, 8'd0, 32'd0);
    offer(gbnsc_pkg::OpTimeout, 8'd0, 32'd0);
    wait_drained();
  endtask

  task automatic test_transfer_extremes();
    // Zero packet count acts as one packet; an oversized window is capped.
    configure(32'd0, 5'd31, 16'hFFFF, 8'd0);
    offer(gbnsc_pkg::OpStart, 8'd0, 32'd0);
    offer(gbnsc_pkg::OpReply, 8'd0, 32'd0);
    offer(gbnsc_pkg::OpStart, 8'd0, 32'd0);
    offer(gbnsc_pkg::OpReply, gbnsc_pkg::TypeDataAck, 32'hFFFF_FFFF);
    offer(gbnsc_pkg::OpTimeout, 8'd0, 32'd0);
    offer(gbnsc_pkg::OpReply, gbnsc_pkg::TypeFinAck, 32'd0);
    offer(gbnsc_pkg::OpReply, gbnsc_pkg::TypeFinAck, 32'd0);
    wait_drained();
  endtask

  task automatic test_window_moves();
    configure(32'hFFFF_FFFF, 5'd16, 16'd3, 8'h3C);
    offer(gbnsc_pkg::OpStart, 8'd0, 32'd0);
    offer(gbnsc_pkg::OpReply, 8'h3C, 32'd0);
    offer(gbnsc_pkg::OpReply, 8'hFF, 32'd0);
    offer(gbnsc_pkg::OpReply, gbnsc_pkg::TypeDataAck, 32'd3);
    offer(gbnsc_pkg::OpReply, gbnsc_pkg::TypeDataAck, 32'd1);
    // An ack far past the sent packets leaves next behind the new base.
    offer(gbnsc_pkg::OpReply, gbnsc_pkg::TypeDataAck, 32'h7FFF_FFFF);
    offer(gbnsc_pkg::OpTimeout, 8'd0, 32'd0);
    wait_drained();
    // Shrinking the transfer below the base ends the data phase.
    write_reg(gbnsc_pkg::CfgPacketCount, 32'd2);
    offer(gbnsc_pkg::OpReply, gbnsc_pkg::TypeDataAck, 32'd0);
    offer(gbnsc_pkg::OpTimeout, 8'd0, 32'd0);
    offer(gbnsc_pkg::OpReply, gbnsc_pkg::TypeFinAck, 32'd0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    configure(32'd200, 5'd16, 16'd3, 8'd7);
    hold_left = 300;
    offer(gbnsc_pkg::OpStart, 8'd0, 32'd0);
    offer(gbnsc_pkg::OpReply, 8'd7, 32'd0);
    repeat (6) offer(gbnsc_pkg::OpTimeout, 8'd0, 32'd0);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int                  idle_mix[4];
    int                  stall_mix[4];
    int unsigned         sent_here;
    gbnsc_pkg::in_item_t it;
    bit                  acted;
    idle_mix = '{0, 88, 0, 30};
    stall_mix = '{0, 0, 88, 30};
    foreach (idle_mix[m]) begin
      idle_pct = idle_mix[m];
      stall_pct = stall_mix[m];
      sent_here = 0;
      while (sent_here < RandEvents) begin
        if (sent_here % 25 == 0) begin
          wait_drained();
          // Mostly short transfers; now and then a huge one ended by a wide ack.
          configure(($urandom_range(5) == 0) ? $urandom : $urandom_range(40, 1),
                    5'($urandom_range(31)), 16'($urandom_range(6)),
                    8'($urandom_range(255)));
        end
        it = pick_event();
        offer_event(it, acted);
        sent_here++;
      end
    end
    wait_drained();
  endtask

  // Receiver side: random stalls, or a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 40) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_checked++;
      if (cmds_due.size() == 0) begin
        errors++;
        $display("%0t: send beat with nothing pending: kind %0d seq %0h last %0b status %0d",
                 $time, out_item_o.send_kind, out_item_o.send_sequence,
                 out_item_o.last, out_item_o.status);
      end else begin
        head_cmd = cmds_due.pop_front();
        compare_field("send_kind", 32'(head_cmd.send_kind), 32'(out_item_o.send_kind));
        compare_field("send_sequence", head_cmd.send_sequence, out_item_o.send_sequence);
        compare_field("last", 32'(head_cmd.last), 32'(out_item_o.last));
        compare_field("status", 32'(head_cmd.status), 32'(out_item_o.status));
      end
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Run stopped at the cycle limit with %0d send beats outstanding.",
             cmds_due.size());
    $display("testbench failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_handshake_failures();
    test_transfer_extremes();
    test_window_moves();
    test_backpressure();
    test_random_traffic();
    $display("Covered %0d events (%0d acted on) and %0d send beats; input held %0d cycles.",
             events_sent, events_acted, beats_checked, input_stalls);
    $display("Transfers: %0d completed, %0d header failures, %0d FIN failures.",
             done_cnt, hdr_fail_cnt, fin_fail_cnt);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
